>>> src/hfp_pkg.sv
`timescale 1ns / 1ps
package hfp_pkg;

    localparam int HDR_BYTES = 9;
    localparam int IDX_W     = 4;
    localparam int LEN_W     = 24;
    localparam int PADDR_W   = 3;
    localparam int TDATA_W   = 144;

    localparam logic [LEN_W-1:0] MAX_FRAME_RST = 24'd16384;

    localparam logic CFG_IDX_MAX_FRAME = 1'b0;

    localparam logic [3:0] TYPE_DATA     = 4'd0;
    localparam logic [3:0] TYPE_HEADERS  = 4'd1;
    localparam logic [3:0] TYPE_PRIORITY = 4'd2;
    localparam logic [3:0] TYPE_RST      = 4'd3;
    localparam logic [3:0] TYPE_SETTINGS = 4'd4;
    localparam logic [3:0] TYPE_PUSH     = 4'd5;
    localparam logic [3:0] TYPE_PING     = 4'd6;
    localparam logic [3:0] TYPE_GOAWAY   = 4'd7;
    localparam logic [3:0] TYPE_WINDOW   = 4'd8;
    localparam logic [3:0] TYPE_UNKNOWN  = 4'd10;

    localparam int FLAG_ACK_BIT    = 0;
    localparam int FLAG_PADDED_BIT = 3;
    localparam int FLAG_PRIO_BIT   = 5;

    typedef struct packed {
        logic              status;
        logic [3:0]        frame_type;
        logic [7:0]        frame_flags;
        logic [31:0]       stream_id;
        logic [LEN_W-1:0]  payload_length;
        logic [7:0]        pad_length;
        logic [LEN_W-1:0]  data_length;
        logic              has_priority;
        logic [31:0]       dependency_word;
        logic [7:0]        priority_weight;
    } t_result;

    // x mod 6 for x < 512: reciprocal multiply, then one correction
    function automatic logic [2:0] mod6(input logic [8:0] x);
        logic [16:0] prod;
        logic [6:0]  q;
        logic [9:0]  r;
        prod = {8'd0, x} * 17'd171;
        q    = prod[16:10];
        r    = {1'b0, x} - ({3'd0, q} * 10'd6);
        if (r >= 10'd6) begin
            r = r - 10'd6;
        end
        return r[2:0];
    endfunction

endpackage

>>> src/hfp_cfg.sv
`timescale 1ns / 1ps
module hfp_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hfp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [hfp_pkg::LEN_W-1:0]   o_max_frame
);
    import hfp_pkg::*;

    logic [LEN_W-1:0] r_max_frame;
    logic             sel_max;

    assign sel_max = (paddr[PADDR_W-1] == CFG_IDX_MAX_FRAME);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RST;
        end else if (psel && penable && pwrite && sel_max) begin
            r_max_frame <= pwdata[LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (sel_max) begin
            prdata = {8'd0, r_max_frame};
        end
    end

    assign o_max_frame = r_max_frame;

endmodule

>>> src/hfp_core.sv
`timescale 1ns / 1ps
module hfp_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [7:0]                i_byte,
    input  logic [hfp_pkg::LEN_W-1:0] i_max_frame,
    output logic                      o_res_valid,
    output hfp_pkg::t_result          o_res
);
    import hfp_pkg::*;

    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_BYTES - 1);

    logic [7:0]       r_hdr [HDR_BYTES];
    logic [IDX_W-1:0] r_idx;
    logic             r_payload;
    logic [LEN_W-1:0] r_cnt;
    logic [2:0]       r_mod6;
    logic [7:0]       r_pad;
    logic [31:0]      r_dep;
    logic [7:0]       r_weight;
    logic             r_halted;

    logic [7:0]       last_hdr;
    logic [LEN_W-1:0] len;
    logic [3:0]       frm_type;
    logic [7:0]       flags;
    logic [31:0]      sid;
    logic             padded;
    logic             prio;
    logic [LEN_W-1:0] prio_lo;
    logic [8:0]       mod_in;
    logic [2:0]       n_mod6;
    logic             hdr_ok;
    logic             hdr_done;
    logic             last;
    logic             work;
    logic [7:0]       pad_cur;
    logic [31:0]      dep_cur;
    logic [7:0]       weight_cur;
    logic [LEN_W:0]   rem_pad;
    logic             pad_bad;
    logic [LEN_W-1:0] rem;
    logic             bad_fin;
    logic [LEN_W-1:0] dlen;
    logic             status;

    assign work     = i_valid && !r_halted;
    assign last_hdr = r_payload ? r_hdr[HDR_BYTES-1] : i_byte;
    assign len      = {r_hdr[0], r_hdr[1], r_hdr[2]};
    assign frm_type = (r_hdr[3] >= 8'(TYPE_UNKNOWN)) ? TYPE_UNKNOWN : r_hdr[3][3:0];
    assign flags    = r_hdr[4];
    assign sid      = {r_hdr[5], r_hdr[6], r_hdr[7], last_hdr};
    assign padded   = (frm_type == TYPE_DATA || frm_type == TYPE_HEADERS ||
                       frm_type == TYPE_PUSH) && flags[FLAG_PADDED_BIT];
    assign prio     = (frm_type == TYPE_PRIORITY) ||
                      (frm_type == TYPE_HEADERS && flags[FLAG_PRIO_BIT]);
    assign prio_lo  = LEN_W'(frm_type == TYPE_HEADERS && padded);

    // running residue of the length field, one byte at a time
    assign mod_in = ((r_idx == '0) ? 9'd0 : {4'd0, r_mod6, 2'b00}) + {1'b0, i_byte};
    assign n_mod6 = mod6(mod_in);

    always_comb begin
        hdr_ok = 1'b1;
        case (frm_type) inside
            TYPE_SETTINGS:         hdr_ok = flags[FLAG_ACK_BIT] ? (len == '0) : (r_mod6 == 3'd0);
            TYPE_PRIORITY:         hdr_ok = (len == 24'd5);
            TYPE_PING:             hdr_ok = (len == 24'd8);
            TYPE_GOAWAY:           hdr_ok = (len >= 24'd8);
            TYPE_RST, TYPE_WINDOW: hdr_ok = (len == 24'd4);
            TYPE_PUSH:             hdr_ok = (len >= 24'd4);
            default:               hdr_ok = 1'b1;
        endcase
        if (len > i_max_frame) begin
            hdr_ok = 1'b0;
        end
    end

    assign hdr_done = !r_payload && (r_idx == HDR_LAST);
    assign last     = r_payload && (({1'b0, r_cnt} + 25'd1) == {1'b0, len});

    assign pad_cur    = (r_payload && padded && r_cnt == '0) ? i_byte : r_pad;
    assign dep_cur    = (r_payload && prio && r_cnt >= prio_lo && r_cnt <= prio_lo + 24'd3) ?
                        {r_dep[23:0], i_byte} : r_dep;
    assign weight_cur = (r_payload && prio && r_cnt == prio_lo + 24'd4) ? i_byte : r_weight;

    assign rem_pad = {1'b0, len} - 25'd1 - {17'd0, pad_cur};
    assign pad_bad = (len == '0) || ({16'd0, pad_cur} >= len);
    assign rem     = padded ? rem_pad[LEN_W-1:0] : len;
    assign bad_fin = (padded && pad_bad) ||
                     (frm_type == TYPE_HEADERS && prio && rem < 24'd5) ||
                     (frm_type == TYPE_PUSH && rem < 24'd4);
    assign dlen    = prio ? (rem - 24'd5) : rem;
    assign status  = hdr_done ? (!hdr_ok || bad_fin) : bad_fin;

    assign o_res_valid = work && ((hdr_done && (!hdr_ok || len == '0)) || last);

    always_comb begin
        o_res.status          = status;
        o_res.frame_type      = frm_type;
        o_res.frame_flags     = flags;
        o_res.stream_id       = sid;
        o_res.payload_length  = len;
        o_res.pad_length      = (!status && padded) ? pad_cur : 8'd0;
        o_res.data_length     = status ? '0 : dlen;
        o_res.has_priority    = !status && prio;
        o_res.dependency_word = (!status && prio) ? dep_cur : 32'd0;
        o_res.priority_weight = (!status && prio) ? weight_cur : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (work && !r_payload) begin
            r_hdr[r_idx] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_payload <= 1'b0;
            r_cnt     <= '0;
            r_mod6    <= '0;
            r_pad     <= '0;
            r_dep     <= '0;
            r_weight  <= '0;
            r_halted  <= 1'b0;
        end else if (work) begin
            if (!r_payload) begin
                if (r_idx < IDX_W'(3)) begin
                    r_mod6 <= n_mod6;
                end
                if (hdr_done) begin
                    r_pad    <= '0;
                    r_dep    <= '0;
                    r_weight <= '0;
                    r_idx    <= '0;
                    if (!hdr_ok) begin
                        r_halted <= 1'b1;
                    end else if (len == '0) begin
                        r_halted <= bad_fin;
                    end else begin
                        r_payload <= 1'b1;
                        r_cnt     <= '0;
                    end
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end else begin
                r_pad    <= pad_cur;
                r_dep    <= dep_cur;
                r_weight <= weight_cur;
                r_cnt    <= r_cnt + 24'd1;
                if (last) begin
                    r_payload <= 1'b0;
                    r_idx     <= '0;
                    r_halted  <= bad_fin;
                end
            end
        end
    end

endmodule

>>> src/hfp_out.sv
`timescale 1ns / 1ps
module hfp_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hfp_pkg::t_result              i_res,
    output logic                          o_ready,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [hfp_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tuser
);
    import hfp_pkg::*;

    logic               r_valid;
    logic [TDATA_W-1:0] r_data;
    logic               r_user;

    assign o_ready = !r_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_user <= i_res.status;
            r_data <= {3'd0, i_res.priority_weight, i_res.dependency_word, i_res.has_priority,
                       i_res.data_length, i_res.pad_length, i_res.payload_length,
                       i_res.stream_id, i_res.frame_flags, i_res.frame_type};
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tuser  = r_user;

endmodule

>>> src/http2_frame_parse_validate.sv
`timescale 1ns / 1ps
// HTTP/2 frame header parser: takes the received byte stream one beat per cycle
// while ready is high, gathers each 9-byte frame header, checks the per-type
// size rules and the max_frame_size register, counts off the payload (capturing
// pad length, dependency word and weight) and gives one result beat per frame,
// passed through the input register and then the result register. Throughput is
// one byte per cycle when the output does not stall; input ready follows the
// output register's ready in the same cycle. Payload bytes are consumed, not
// forwarded. After a size error every byte is dropped without a result until
// reset.
module http2_frame_parse_validate (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [7:0] stream_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [3:0] frame_type, [11:4] frame_flags, [43:12] stream_id,
    // [67:44] payload_length, [75:68] pad_length, [99:76] data_length,
    // [100] has_priority, [132:101] dependency_word, [140:133] priority_weight
    output logic [hfp_pkg::TDATA_W-1:0]   o_m_axis_tdata,
    output logic                          o_m_axis_tuser,   // [0] status
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hfp_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import hfp_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             out_ready;
    logic             advance;
    logic [LEN_W-1:0] max_frame;
    logic             res_valid;
    t_result          res;

    assign advance         = r_in_valid && out_ready;
    assign o_s_axis_tready = !r_in_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    hfp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_max_frame (max_frame)
    );

    hfp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_byte      (r_in_byte),
        .i_max_frame (max_frame),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    hfp_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (res_valid),
        .i_res           (res),
        .o_ready         (out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

>>> bench/http2_frame_checker.sv
`timescale 1ns / 1ps
module http2_frame_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_valid,
    input  logic                          i_s_ready,
    input  logic [7:0]                    i_s_data,
    input  logic                          i_m_valid,
    input  logic                          i_m_ready,
    input  logic [hfp_pkg::TDATA_W-1:0]   i_m_data,
    input  logic                          i_m_user,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [hfp_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic [31:0]                   i_prdata,
    input  logic                          i_pready,
    output int                            o_pending,
    output int                            o_errors,
    output int                            o_checked
);
    import hfp_pkg::*;

    logic [7:0]  hdr_q [HDR_BYTES];
    int unsigned frame_pos;
    logic [7:0]  pad_val;
    logic [31:0] dep_word;
    logic [7:0]  weight_val;
    logic        halted;
    logic [23:0] max_len;
    t_result     frames_due[$];

    function automatic logic [23:0] hdr_len();
        return {hdr_q[0], hdr_q[1], hdr_q[2]};
    endfunction

    function automatic logic [3:0] hdr_kind();
        return (hdr_q[3] >= {4'd0, TYPE_UNKNOWN}) ? TYPE_UNKNOWN : hdr_q[3][3:0];
    endfunction

    function automatic logic padded_frame();
        logic [3:0] k;
        k = hdr_kind();
        return (k == TYPE_DATA || k == TYPE_HEADERS || k == TYPE_PUSH) &&
               hdr_q[4][FLAG_PADDED_BIT];
    endfunction

    function automatic logic prio_frame();
        logic [3:0] k;
        k = hdr_kind();
        return k == TYPE_PRIORITY || (k == TYPE_HEADERS && hdr_q[4][FLAG_PRIO_BIT]);
    endfunction

    function automatic logic header_fits();
        logic [23:0] len;
        len = hdr_len();
        if (len > max_len) return 1'b0;
        case (hdr_kind())
            TYPE_SETTINGS: return hdr_q[4][FLAG_ACK_BIT] ? (len == 0) : (len % 6 == 0);
            TYPE_PRIORITY: return len == 5;
            TYPE_PING:     return len == 8;
            TYPE_GOAWAY:   return len >= 8;
            TYPE_RST,
            TYPE_WINDOW:   return len == 4;
            TYPE_PUSH:     return len >= 4;
            default:       return 1'b1;
        endcase
    endfunction

    task automatic push_result(input logic bad, input logic [7:0] pad,
                               input logic [23:0] dlen, input logic pri);
        t_result r;
        r.status          = bad;
        r.frame_type      = hdr_kind();
        r.frame_flags     = hdr_q[4];
        r.stream_id       = {hdr_q[5], hdr_q[6], hdr_q[7], hdr_q[8]};
        r.payload_length  = hdr_len();
        r.pad_length      = bad ? 8'd0 : pad;
        r.data_length     = bad ? 24'd0 : dlen;
        r.has_priority    = !bad && pri;
        r.dependency_word = (!bad && pri) ? dep_word : 32'd0;
        r.priority_weight = (!bad && pri) ? weight_val : 8'd0;
        frames_due.push_back(r);
    endtask

    task automatic close_frame();
        int unsigned len;
        int unsigned rem;
        logic        bad;
        logic        pd;
        logic        pr;
        logic [3:0]  k;
        len = hdr_len();
        k   = hdr_kind();
        pd  = padded_frame();
        pr  = prio_frame();
        bad = 1'b0;
        rem = len;
        frame_pos = 0;
        if (k != TYPE_UNKNOWN) begin
            if (pd) begin
                if (len == 0 || pad_val >= len) bad = 1'b1;
                else rem = len - 1 - pad_val;
            end
            if (!bad && k == TYPE_HEADERS && pr && rem < 5) bad = 1'b1;
            if (!bad && k == TYPE_PUSH && rem < 4) bad = 1'b1;
        end
        if (!bad && pr) rem -= 5;
        if (bad) halted = 1'b1;
        push_result(bad, pd ? pad_val : 8'd0, rem[23:0], pr);
    endtask

    task automatic take_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned base;
        if (halted) return;
        if (frame_pos < HDR_BYTES) begin
            hdr_q[frame_pos] = b;
            frame_pos++;
            if (frame_pos == HDR_BYTES) begin
                pad_val    = 8'd0;
                dep_word   = 32'd0;
                weight_val = 8'd0;
                if (!header_fits()) begin
                    frame_pos = 0;
                    halted    = 1'b1;
                    push_result(1'b1, 8'd0, 24'd0, 1'b0);
                end else if (hdr_len() == 0) begin
                    close_frame();
                end
            end
        end else begin
            pos = frame_pos - HDR_BYTES;
            if (padded_frame() && pos == 0) pad_val = b;
            if (prio_frame()) begin
                base = (hdr_kind() == TYPE_HEADERS && padded_frame()) ? 1 : 0;
                if (pos >= base && pos < base + 4) dep_word = {dep_word[23:0], b};
                else if (pos == base + 4) weight_val = b;
            end
            frame_pos++;
            if (frame_pos - HDR_BYTES >= hdr_len()) close_frame();
        end
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            o_errors++;
        end
    endtask

    task automatic check_beat();
        t_result want;
        if (frames_due.size() == 0) begin
            $error("result beat with no frame outstanding: tdata 0x%0h", i_m_data);
            o_errors++;
            return;
        end
        want = frames_due.pop_front();
        o_checked++;
        cmp_field("status",          want.status,          i_m_user);
        cmp_field("frame_type",      want.frame_type,      i_m_data[3:0]);
        cmp_field("frame_flags",     want.frame_flags,     i_m_data[11:4]);
        cmp_field("stream_id",       want.stream_id,       i_m_data[43:12]);
        cmp_field("payload_length",  want.payload_length,  i_m_data[67:44]);
        cmp_field("pad_length",      want.pad_length,      i_m_data[75:68]);
        cmp_field("data_length",     want.data_length,     i_m_data[99:76]);
        cmp_field("has_priority",    want.has_priority,    i_m_data[100]);
        cmp_field("dependency_word", want.dependency_word, i_m_data[132:101]);
        cmp_field("priority_weight", want.priority_weight, i_m_data[140:133]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos  = 0;
            pad_val    = 8'd0;
            dep_word   = 32'd0;
            weight_val = 8'd0;
            halted     = 1'b0;
            max_len    = MAX_FRAME_RST;
            frames_due.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr[PADDR_W-1:2] == CFG_IDX_MAX_FRAME) begin
                if (i_pwrite) begin
                    max_len = i_pwdata[23:0];
                end else if (i_prdata !== {8'd0, max_len}) begin
                    $error("max_frame_size: expected 0x%0h, got 0x%0h", max_len, i_prdata);
                    o_errors++;
                end
            end
            if (i_m_valid && i_m_ready) check_beat();
            if (i_s_valid && i_s_ready) take_byte(i_s_data);
        end
        o_pending <= frames_due.size();
    end

endmodule

>>> bench/tb_http2_frame_parse_validate.sv
`timescale 1ns / 1ps
module tb_http2_frame_parse_validate;
    import hfp_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_MAX_FRAME     = {CFG_IDX_MAX_FRAME, 2'b00};
    localparam logic [7:0]         KIND_CONTINUATION  = 8'd9;
    localparam logic [7:0]         KIND_RAW_TOP       = 8'hFF;
    localparam logic [7:0]         FL_ACK             = 8'(1 << FLAG_ACK_BIT);
    localparam logic [7:0]         FL_PAD             = 8'(1 << FLAG_PADDED_BIT);
    localparam logic [7:0]         FL_PRI             = 8'(1 << FLAG_PRIO_BIT);
    localparam logic [23:0]        MAX_FRAME_TOP      = 24'hFFFFFF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic [7:0]           s_axis_tdata = 8'd0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = 32'd0;
    logic [31:0]          prdata;
    logic                 pready;

    int          pending;
    int          errors;
    int          checked;
    int unsigned src_idle = 0;
    int unsigned sink_stall = 0;
    int unsigned bytes_sent = 0;
    int unsigned bytes_dropped = 0;
    logic [23:0] max_len = MAX_FRAME_RST;

    http2_frame_parse_validate DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    http2_frame_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata),
        .i_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_m_data  (m_axis_tdata),
        .i_m_user  (m_axis_tuser),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .i_prdata  (prdata),
        .i_pready  (pready),
        .o_pending (pending),
        .o_errors  (errors),
        .o_checked (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= sink_stall);
    end

    initial begin
        #10ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99, 0) < src_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < src_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [23:0] len, input logic [7:0] kind,
                               input logic [7:0] flags, input logic [31:0] sid);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(kind);
        send_byte(flags);
        send_byte(sid[31:24]);
        send_byte(sid[23:16]);
        send_byte(sid[15:8]);
        send_byte(sid[7:0]);
    endtask

    // lead is the first payload byte: the pad count on padded frames
    task automatic send_frame(input logic [23:0] len, input logic [7:0] kind,
                              input logic [7:0] flags, input logic [31:0] sid,
                              input logic [7:0] lead);
        send_header(len, kind, flags, sid);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(i == 0 ? lead : 8'($urandom));
        end
    endtask

    task automatic send_random_frame();
        logic [7:0]  kind;
        logic [7:0]  flags;
        logic [7:0]  lead;
        logic [23:0] len;
        int unsigned need;
        kind  = ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 10))
                                            : 8'($urandom_range(9, 0));
        flags = 8'($urandom);
        lead  = 8'($urandom);
        len   = ($urandom_range(15, 0) == 0) ? 24'($urandom_range(300, 0))
                                             : 24'($urandom_range(24, 0));
        case (kind)
            8'(TYPE_DATA), 8'(TYPE_HEADERS), 8'(TYPE_PUSH): begin
                need = (kind == 8'(TYPE_PUSH)) ? 4 :
                       (kind == 8'(TYPE_HEADERS) && flags[FLAG_PRIO_BIT]) ? 5 : 0;
                if (flags[FLAG_PADDED_BIT]) begin
                    lead = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, 0))
                                                       : 8'($urandom_range(12, 0));
                    len  = 24'(1 + lead + need + $urandom_range(12, 0));
                end else if (len < need) begin
                    len = 24'(need + $urandom_range(12, 0));
                end
            end
            8'(TYPE_PRIORITY):               len = 24'd5;
            8'(TYPE_RST), 8'(TYPE_WINDOW):   len = 24'd4;
            8'(TYPE_PING):                   len = 24'd8;
            8'(TYPE_GOAWAY):                 len = 24'(8 + $urandom_range(16, 0));
            8'(TYPE_SETTINGS):               len = flags[FLAG_ACK_BIT] ? 24'd0
                                                   : 24'(6 * $urandom_range(4, 0));
            default: ;
        endcase
        send_frame(len, kind, flags, $urandom, lead);
    endtask

    // one size error halts the parser for good, so this goes last
    task automatic send_bad_frame();
        logic [7:0] lead;
        lead = 8'($urandom_range(6, 0));
        case ($urandom_range(7, 0))
            0: send_header(max_len + 24'd1, 8'(TYPE_DATA), 8'($urandom), $urandom);
            1: send_header(24'(6 * $urandom_range(3, 0) + $urandom_range(5, 1)),
                           8'(TYPE_SETTINGS), 8'($urandom) & ~FL_ACK, $urandom);
            2: send_header(24'd7, 8'(TYPE_PING), 8'($urandom), $urandom);
            3: send_header(24'($urandom_range(7, 0)), 8'(TYPE_GOAWAY), 8'($urandom),
                           $urandom);
            4: begin
                lead = 8'($urandom_range(20, 1));
                send_frame(24'($urandom_range(lead, 1)), 8'(TYPE_DATA), FL_PAD, $urandom,
                           lead);
            end
            5: send_frame(24'(1 + lead + $urandom_range(4, 0)), 8'(TYPE_HEADERS),
                          FL_PAD | FL_PRI, $urandom, lead);
            6: send_frame(24'(1 + lead + $urandom_range(3, 0)), 8'(TYPE_PUSH),
                          FL_PAD, $urandom, lead);
            default: send_header(24'd0, 8'(TYPE_DATA), FL_PAD, $urandom);
        endcase
    endtask

    task automatic apb_access(input logic wr, input logic [23:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_FRAME;
        pwdata  <= {8'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (wr) max_len = v;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (4) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned phase_end;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apb_access(1'b0, 24'd0);

        send_header(24'd0, 8'(TYPE_DATA), 8'h00, 32'h0000_0000);
        send_header(24'd0, 8'(TYPE_SETTINGS), FL_ACK, $urandom);
        send_frame(24'd6, 8'(TYPE_SETTINGS), 8'h00, $urandom, 8'($urandom));
        send_frame(24'd5, 8'(TYPE_PRIORITY), 8'h00, 32'hFFFF_FFFF, 8'hFF);
        send_frame(24'd6, 8'(TYPE_HEADERS), FL_PAD | FL_PRI, $urandom, 8'd0);
        send_frame(24'd5, 8'(TYPE_HEADERS), FL_PRI, $urandom, 8'($urandom));
        send_frame(24'd4, 8'(TYPE_DATA), FL_PAD, $urandom, 8'd3);
        send_frame(24'd7, 8'(TYPE_PUSH), FL_PAD, $urandom, 8'd2);
        send_frame(24'd4, 8'(TYPE_RST), 8'h00, $urandom, 8'($urandom));
        send_frame(24'd4, 8'(TYPE_WINDOW), 8'h00, $urandom, 8'($urandom));
        send_frame(24'd8, 8'(TYPE_PING), 8'hFF, $urandom, 8'($urandom));
        send_frame(24'd8, 8'(TYPE_GOAWAY), 8'h00, $urandom, 8'($urandom));
        send_frame(24'd3, KIND_CONTINUATION, 8'hFF, $urandom, 8'($urandom));
        send_frame(24'd7, KIND_RAW_TOP, 8'hFF, $urandom, 8'($urandom));
        send_header(24'd0, 8'(TYPE_UNKNOWN), FL_PAD, $urandom);
        drain();
        apb_access(1'b1, MAX_FRAME_TOP);
        apb_access(1'b0, 24'd0);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin src_idle = 0;  sink_stall = 0;  end
                1: begin src_idle = 81; sink_stall = 0;  end
                2: begin src_idle = 0;  sink_stall = 81; end
                default: begin src_idle = 35; sink_stall = 35; end
            endcase
            if (ph == 3) apb_access(1'b1, MAX_FRAME_RST);
            else apb_access(1'b1, 24'($urandom_range(MAX_FRAME_TOP, MAX_FRAME_RST)));
            phase_end = bytes_sent + 115;
            while (bytes_sent < phase_end) send_random_frame();
        end

        send_bad_frame();
        phase_end = bytes_sent;
        repeat (30) send_byte(8'($urandom));
        bytes_dropped = bytes_sent - phase_end;
        drain();

        if (pending != 0) $error("%0d frame results never arrived", pending);
        $display("Run: %0d bytes in (%0d dropped after the size error), %0d results checked",
                 bytes_sent, bytes_dropped, checked);
        $display("All frame types, padding and priority, four idle mixes, max size reg swept");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
